// ----- rtl/grid_longest_descent_assert.svh -----
// Assertion macros shared by the grid_longest_descent RTL.
// Needs a clk and rst in scope where used.
`ifndef GRID_LONGEST_DESCENT_ASSERT_SVH
`define GRID_LONGEST_DESCENT_ASSERT_SVH

// Same-cycle implication, off during reset
`define GLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define GLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gld_pkg.sv -----
// Shared types and constants for grid_longest_descent.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gld_pkg;

  localparam int ROW_W    = 7;
  localparam int CELL_W   = 2 * ROW_W;
  localparam int CELLS    = 1 << CELL_W;
  localparam int SP_W     = CELL_W + 1;
  localparam int LEN_W    = 15;
  localparam int HEIGHT_W = 32;
  localparam int DIR_W    = 3;
  localparam int DIM_W    = 8;
  localparam int IDX_W    = 4;

  localparam logic [DIM_W-1:0] MAX_DIM  = 8'd128;
  localparam logic [IDX_W-1:0] REG_ROWS = 4'd0;
  localparam logic [IDX_W-1:0] REG_COLS = 4'd1;
  localparam logic [DIR_W-1:0] DIR_DONE = 3'd4;

  // Load request from the input side
  typedef struct packed {
    logic                       we;
    logic                       restart;
    logic signed [HEIGHT_W-1:0] height;
  } gld_load_t;

  // Finished result offered to the output register
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
  } gld_result_t;

  // One suspended walk frame
  typedef struct packed {
    logic [ROW_W-1:0]           row;
    logic [ROW_W-1:0]           col;
    logic [DIR_W-1:0]           dir;
    logic [LEN_W-1:0]           len;
    logic signed [HEIGHT_W-1:0] height;
  } gld_frame_t;

endpackage

`default_nettype wire

// ----- rtl/gld_step_unit.sv -----
// Shared compare/max unit of the walk sequencer.
// Depends on gld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gld_step_unit import gld_pkg::*; (
  input  wire logic signed [HEIGHT_W-1:0] cur_h,
  input  wire logic signed [HEIGHT_W-1:0] nb_h,
  input  wire logic [LEN_W-1:0]           a,
  input  wire logic [LEN_W-1:0]           b,
  input  wire logic                       inc,
  output      logic                       lower,
  output      logic [LEN_W-1:0]           y
);

  logic [LEN_W:0] b_inc;

  // strict descent test
  assign lower = nb_h < cur_h;

  // y = max(a, b + inc)
  assign b_inc = {1'b0, b} + {{LEN_W{1'b0}}, inc};
  assign y     = (b_inc > {1'b0, a}) ? b_inc[LEN_W-1:0] : a;

endmodule

`default_nettype wire

// ----- rtl/gld_walk.sv -----
// Grid store, memo store, walk stack and the sequencer that runs the search.
// Depends on gld_pkg, gld_step_unit and grid_longest_descent_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_longest_descent_assert.svh"

module gld_walk import gld_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DIM_W-1:0] rows,
  input  wire logic [DIM_W-1:0] cols,
  input  wire gld_load_t        load,
  output      logic             load_ready,
  output      gld_result_t      result,
  input  wire logic             result_ack
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SRD   = 3'd2;
  localparam logic [2:0] ST_SCHK  = 3'd3;
  localparam logic [2:0] ST_WDIR  = 3'd4;
  localparam logic [2:0] ST_WEVAL = 3'd5;
  localparam logic [2:0] ST_WPOP  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // storage
  logic signed [HEIGHT_W-1:0] height_mem [CELLS];
  logic [LEN_W-1:0]           memo_mem   [CELLS];
  gld_frame_t                 stack_mem  [CELLS];

  logic [2:0]                 state;
  logic [ROW_W-1:0]           lr, lc;     // load / clear position
  logic [ROW_W-1:0]           sr, sc;     // start cell
  logic [ROW_W-1:0]           cr, cc;     // current cell
  logic [ROW_W-1:0]           nr, nc;     // neighbor under test
  logic [DIR_W-1:0]           dir;
  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           best;
  logic signed [HEIGHT_W-1:0] cur_h;
  logic [SP_W-1:0]            sp;

  logic signed [HEIGHT_W-1:0] h_rd;
  logic [LEN_W-1:0]           m_rd;
  gld_frame_t                 st_rd;

  logic [CELL_W-1:0]          h_raddr, m_raddr, m_waddr;
  logic                       m_we;
  logic [LEN_W-1:0]           m_wdata;
  logic                       st_we;
  gld_frame_t                 st_wdata;
  logic [SP_W-1:0]            sp_dec;

  logic                       nb_ok;
  logic [ROW_W-1:0]           nb_r, nb_c;
  logic                       load_last_col, load_last_row, s_last;

  logic [LEN_W-1:0]           u_a, u_b, u_y;
  logic                       u_inc, u_lower;

  gld_step_unit u_step (
    .cur_h (cur_h),
    .nb_h  (h_rd),
    .a     (u_a),
    .b     (u_b),
    .inc   (u_inc),
    .lower (u_lower),
    .y     (u_y)
  );

  assign load_last_col = ({1'b0, lc} + 8'd1) == cols;
  assign load_last_row = ({1'b0, lr} + 8'd1) == rows;
  assign s_last = (({1'b0, sc} + 8'd1) == cols) && (({1'b0, sr} + 8'd1) == rows);
  assign sp_dec = sp - 1'b1;

  // neighbor of the current cell in direction dir
  always_comb begin
    nb_r  = cr;
    nb_c  = cc;
    nb_ok = 1'b0;
    unique case (dir[1:0])
      2'd0: begin
        nb_c  = cc + 1'b1;
        nb_ok = ({1'b0, cc} + 8'd1) < cols;
      end
      2'd1: begin
        nb_c  = cc - 1'b1;
        nb_ok = cc != '0;
      end
      2'd2: begin
        nb_r  = cr + 1'b1;
        nb_ok = ({1'b0, cr} + 8'd1) < rows;
      end
      default: begin
        nb_r  = cr - 1'b1;
        nb_ok = cr != '0;
      end
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    u_a   = len;
    u_b   = m_rd;
    u_inc = 1'b1;
    unique case (state)
      ST_SCHK: begin
        u_a   = best;
        u_b   = m_rd;
        u_inc = 1'b0;
      end
      ST_WDIR: begin
        u_a   = best;
        u_b   = len;
        u_inc = 1'b0;
      end
      ST_WPOP: begin
        u_a   = st_rd.len;
        u_b   = len;
        u_inc = 1'b1;
      end
      default: begin
        u_a   = len;
        u_b   = m_rd;
        u_inc = 1'b1;
      end
    endcase
  end

  // memory address and write control
  always_comb begin
    h_raddr  = {nb_r, nb_c};
    m_raddr  = {nb_r, nb_c};
    m_we     = 1'b0;
    m_waddr  = {cr, cc};
    m_wdata  = len;
    st_we    = 1'b0;
    st_wdata = '{row: cr, col: cc, dir: dir + 1'b1, len: len, height: cur_h};
    if (state == ST_SRD) begin
      h_raddr = {sr, sc};
      m_raddr = {sr, sc};
    end
    if (state == ST_CLEAR) begin
      m_we    = 1'b1;
      m_waddr = {lr, lc};
      m_wdata = '0;
    end
    if (state == ST_WDIR && dir == DIR_DONE) begin
      m_we = 1'b1;
    end
    if (state == ST_WEVAL && u_lower && m_rd == '0) begin
      st_we = 1'b1;
    end
  end

  // storage ports
  always_ff @(posedge clk) begin
    if (load.we && state == ST_LOAD) begin
      height_mem[{lr, lc}] <= load.height;
    end
    h_rd <= height_mem[h_raddr];
    if (m_we) begin
      memo_mem[m_waddr] <= m_wdata;
    end
    m_rd <= memo_mem[m_raddr];
    if (st_we) begin
      stack_mem[sp[CELL_W-1:0]] <= st_wdata;
    end
    st_rd <= stack_mem[sp_dec[CELL_W-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      lr    <= '0;
      lc    <= '0;
      sr    <= '0;
      sc    <= '0;
      sp    <= '0;
      best  <= '0;
      dir   <= '0;
      len   <= '0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (load.restart) begin
            lr <= '0;
            lc <= '0;
          end else if (load.we) begin
            if (load_last_col) begin
              lc <= '0;
              if (load_last_row) begin
                lr    <= '0;
                state <= ST_CLEAR;
              end else begin
                lr <= lr + 1'b1;
              end
            end else begin
              lc <= lc + 1'b1;
            end
          end
        end
        ST_CLEAR: begin
          if (load_last_col) begin
            lc <= '0;
            if (load_last_row) begin
              lr    <= '0;
              sr    <= '0;
              sc    <= '0;
              best  <= '0;
              state <= ST_SRD;
            end else begin
              lr <= lr + 1'b1;
            end
          end else begin
            lc <= lc + 1'b1;
          end
        end
        ST_SRD: begin
          state <= ST_SCHK;
        end
        ST_SCHK: begin
          if (m_rd != '0) begin
            best <= u_y;
            if (s_last) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SRD;
            end
            if (({1'b0, sc} + 8'd1) == cols) begin
              sc <= '0;
              sr <= sr + 1'b1;
            end else begin
              sc <= sc + 1'b1;
            end
          end else begin
            cr    <= sr;
            cc    <= sc;
            cur_h <= h_rd;
            dir   <= '0;
            len   <= LEN_W'(1);
            sp    <= '0;
            state <= ST_WDIR;
          end
        end
        ST_WDIR: begin
          if (dir == DIR_DONE) begin
            if (sp == '0) begin
              best <= u_y;
              if (s_last) begin
                state <= ST_DONE;
              end else begin
                state <= ST_SRD;
              end
              if (({1'b0, sc} + 8'd1) == cols) begin
                sc <= '0;
                sr <= sr + 1'b1;
              end else begin
                sc <= sc + 1'b1;
              end
            end else begin
              sp    <= sp_dec;
              state <= ST_WPOP;
            end
          end else if (nb_ok) begin
            nr    <= nb_r;
            nc    <= nb_c;
            state <= ST_WEVAL;
          end else begin
            dir <= dir + 1'b1;
          end
        end
        ST_WEVAL: begin
          if (u_lower && m_rd == '0) begin
            sp    <= sp + 1'b1;
            cr    <= nr;
            cc    <= nc;
            cur_h <= h_rd;
            dir   <= '0;
            len   <= LEN_W'(1);
          end else begin
            if (u_lower) begin
              len <= u_y;
            end
            dir <= dir + 1'b1;
          end
          state <= ST_WDIR;
        end
        ST_WPOP: begin
          cr    <= st_rd.row;
          cc    <= st_rd.col;
          dir   <= st_rd.dir;
          cur_h <= st_rd.height;
          len   <= u_y;
          state <= ST_WDIR;
        end
        default: begin
          if (result_ack) begin
            state <= ST_LOAD;
          end
        end
      endcase
    end
  end

  assign load_ready   = state == ST_LOAD;
  assign result.valid = state == ST_DONE;
  assign result.len   = best;

  `GLD_ASSERT_NOW(a_sp_bound, 1'b1, sp <= SP_W'(CELLS), "walk stack overflow")
  `GLD_ASSERT_NOW(a_result_nonzero, result.valid, best != '0, "result of zero length")
  `GLD_ASSERT_NEXT(a_eval_returns, state == ST_WEVAL, state == ST_WDIR, "eval did not return")

endmodule

`default_nettype wire

// ----- rtl/grid_longest_descent.sv -----
// Top level of grid_longest_descent: configuration registers, input and output channels.
// Depends on gld_pkg and gld_walk.
//
// Usage: write rows (index 0) and cols (index 1) through cfg_we/cfg_index/cfg_data;
// 0 acts as 1, values above 128 saturate to 128, other indexes are ignored, and
// any register write restarts the grid load. Heights then arrive in row-major
// order on in_valid/in_stall/height, one transfer per cycle while loading.
// After the last cell the block stalls the input and runs the search:
//   memo clear: every memo entry of the grid is zeroed, one cell at a time;
//   walk: each start cell without a memo entry is searched depth-first over its
//   strictly lower neighbors on the walk stack, using the one shared compare/max unit.
// The result is then moved into the output register and shown on
// out_valid/longest_path. The next grid can load while that result waits;
// a finished search waits for the output register to free up if the receiver
// holds out_stall. Reset (rst, synchronous) sets rows = cols = 1, empties
// the output register and returns to loading at the first cell.
`timescale 1ns / 1ps
`default_nettype none

module grid_longest_descent import gld_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [IDX_W-1:0]           cfg_index,
  input  wire logic [DIM_W-1:0]           cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic signed [HEIGHT_W-1:0] height,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [LEN_W-1:0]           longest_path
);

  logic [DIM_W-1:0] rows, cols, cfg_val;
  logic             cfg_hit, load_ready, result_ack;
  gld_load_t        load;
  gld_result_t      result;

  // clamp register writes to 1..128
  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_val = 8'd1;
    end else if (cfg_data > MAX_DIM) begin
      cfg_val = MAX_DIM;
    end else begin
      cfg_val = cfg_data;
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == REG_ROWS || cfg_index == REG_COLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= 8'd1;
      cols <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        rows <= cfg_val;
      end
      if (cfg_index == REG_COLS) begin
        cols <= cfg_val;
      end
    end
  end

  // input transfer
  assign in_stall     = !load_ready;
  assign load.we      = in_valid && load_ready;
  assign load.restart = cfg_hit;
  assign load.height  = height;

  gld_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .rows       (rows),
    .cols       (cols),
    .load       (load),
    .load_ready (load_ready),
    .result     (result),
    .result_ack (result_ack)
  );

  // output register
  assign result_ack = result.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_ack) begin
      longest_path <= result.len;
    end
  end

endmodule

`default_nettype wire
